// File: design/lidar_spherical_to_cartesian_top_defines.svh
// Assertion macros used by the checker file of the point converter.
`ifndef LIDAR_SPHERICAL_TO_CARTESIAN_TOP_DEFINES_SVH
`define LIDAR_SPHERICAL_TO_CARTESIAN_TOP_DEFINES_SVH

// Property checked on every rising edge, switched off while reset is held.
`define LSC_ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every rising edge, reset cycles included.
`define LSC_ASSERT_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/lsc_pkg.sv
package lsc_pkg;

  // Default configuration of the rotation chain.
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ANGLE_BITS_DEF    = 16;

  // Width of the CORDIC x and y registers (Q30 plus growth and sign).
  localparam int XW = 34;

  // Start value of the x register: inverse CORDIC gain in Q30.
  localparam logic signed [XW-1:0] GAIN_Q30 = 34'sd652032874;

  // Port widths.
  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 104;

  // Arctangent of 2^-i in units of 2^32 per turn.
  localparam logic [31:0] ATAN_TURN32 [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // Arctangent of stage idx rounded to an angle of ab bits.
  function automatic logic [32:0] atan_q(input int idx, input int ab);
    logic [32:0] t;
    t = {1'b0, ATAN_TURN32[idx]};
    return (t + (33'd1 << (31 - ab))) >> (32 - ab);
  endfunction

  // Fields of a return that travel beside the rotation lanes.
  typedef struct packed {
    logic        valid_req;
    logic [19:0] range_cm;
    logic [15:0] intensity;
    logic [15:0] channel;
  } side_t;

  // Control handed from cell to cell.
  typedef struct packed {
    logic valid;
    logic flip_az;
    logic flip_el;
  } ctl_t;

  // One point record, x_m in the lowest bits.
  typedef struct packed {
    logic [15:0]        ring;
    logic [15:0]        intensity_out;
    logic signed [22:0] z_m;
    logic signed [22:0] y_m;
    logic signed [22:0] x_m;
  } res_t;

endpackage

// File: design/lsc_cordic_cell.sv
module lsc_cordic_cell #(
  parameter int STAGE      = 0,
  parameter int ANGLE_BITS = lsc_pkg::ANGLE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  lsc_pkg::ctl_t                  ctl_i,
  input  lsc_pkg::side_t                 side_i,
  input  logic signed [lsc_pkg::XW-1:0]  ax_i,
  input  logic signed [lsc_pkg::XW-1:0]  ay_i,
  input  logic signed [ANGLE_BITS:0]     az_i,
  input  logic signed [lsc_pkg::XW-1:0]  ex_i,
  input  logic signed [lsc_pkg::XW-1:0]  ey_i,
  input  logic signed [ANGLE_BITS:0]     ez_i,
  output lsc_pkg::ctl_t                  ctl_o,
  output lsc_pkg::side_t                 side_o,
  output logic signed [lsc_pkg::XW-1:0]  ax_o,
  output logic signed [lsc_pkg::XW-1:0]  ay_o,
  output logic signed [ANGLE_BITS:0]     az_o,
  output logic signed [lsc_pkg::XW-1:0]  ex_o,
  output logic signed [lsc_pkg::XW-1:0]  ey_o,
  output logic signed [ANGLE_BITS:0]     ez_o
);
  import lsc_pkg::*;

  localparam int ZW = ANGLE_BITS + 1;
  localparam logic signed [ZW-1:0] ATAN_A = signed'(ZW'(atan_q(STAGE, ANGLE_BITS)));

  ctl_t                  ctl_r;
  side_t                 side_r;
  logic signed [XW-1:0]  ax_r, ay_r, ex_r, ey_r;
  logic signed [ZW-1:0]  az_r, ez_r;
  logic signed [XW-1:0]  ax_nxt, ay_nxt, ex_nxt, ey_nxt;
  logic signed [ZW-1:0]  az_nxt, ez_nxt;

  // One micro-rotation on each lane, direction from the sign of the residual angle.
  always_comb begin
    if (!az_i[ZW-1]) begin
      ax_nxt = ax_i - (ay_i >>> STAGE);
      ay_nxt = ay_i + (ax_i >>> STAGE);
      az_nxt = az_i - ATAN_A;
    end else begin
      ax_nxt = ax_i + (ay_i >>> STAGE);
      ay_nxt = ay_i - (ax_i >>> STAGE);
      az_nxt = az_i + ATAN_A;
    end
    if (!ez_i[ZW-1]) begin
      ex_nxt = ex_i - (ey_i >>> STAGE);
      ey_nxt = ey_i + (ex_i >>> STAGE);
      ez_nxt = ez_i - ATAN_A;
    end else begin
      ex_nxt = ex_i + (ey_i >>> STAGE);
      ey_nxt = ey_i - (ex_i >>> STAGE);
      ez_nxt = ez_i + ATAN_A;
    end
  end

  // Control register; only the valid bit is cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  // Lane and sideband registers.
  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= side_i;
      ax_r   <= ax_nxt;
      ay_r   <= ay_nxt;
      az_r   <= az_nxt;
      ex_r   <= ex_nxt;
      ey_r   <= ey_nxt;
      ez_r   <= ez_nxt;
    end
  end

  assign ctl_o  = ctl_r;
  assign side_o = side_r;
  assign ax_o   = ax_r;
  assign ay_o   = ay_r;
  assign az_o   = az_r;
  assign ex_o   = ex_r;
  assign ey_o   = ey_r;
  assign ez_o   = ez_r;

endmodule

// File: design/lsc_scale.sv
module lsc_scale (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  lsc_pkg::ctl_t                  ctl_i,
  input  lsc_pkg::side_t                 side_i,
  input  logic signed [lsc_pkg::XW-1:0]  ca_i,
  input  logic signed [lsc_pkg::XW-1:0]  sa_i,
  input  logic signed [lsc_pkg::XW-1:0]  ce_i,
  input  logic signed [lsc_pkg::XW-1:0]  se_i,
  output logic                           valid_o,
  output lsc_pkg::res_t                  res_o
);
  import lsc_pkg::*;

  localparam int LAT = 7;
  localparam logic [52:0] H_BIAS   = 53'd1 << 19;
  localparam logic [52:0] Z_BIAS   = 53'd25 << 23;
  localparam logic [63:0] XY_BIAS  = 64'd25 << 33;
  // ceil(2^32 / 25): exact floor quotient for dividends below 2^30.
  localparam logic [55:0] RECIP_25 = 56'd171798692;
  localparam logic signed [24:0] OUT_MAX = 25'sd4194303;
  localparam logic signed [24:0] OUT_MIN = -25'sd4194304;

  // Apply the sign and saturate to the coordinate range.
  function automatic logic signed [22:0] sat23(input logic [23:0] q, input logic neg);
    logic signed [24:0] v;
    v = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    if (v > OUT_MAX) begin
      return 23'(OUT_MAX);
    end else if (v < OUT_MIN) begin
      return 23'(OUT_MIN);
    end
    return 23'(v);
  endfunction

  logic               v_r  [0:LAT-1];
  side_t              sd_r [0:LAT-2];

  logic signed [31:0] ca0_r, sa0_r, ce0_r, se0_r;
  logic signed [52:0] pce1_r, pse1_r;
  logic signed [31:0] ca1_r, sa1_r, ca2_r, sa2_r;
  logic signed [31:0] h2_r;
  logic [27:0]        nz2_r, nz3_r, nz4_r;
  logic               zn2_r, zn3_r, zn4_r, zn5_r;
  logic signed [63:0] px3_r, py3_r;
  logic [27:0]        nx4_r, ny4_r;
  logic               xn4_r, yn4_r, xn5_r, yn5_r;
  logic [23:0]        qx5_r, qy5_r, qz5_r;
  res_t               res_r;

  logic signed [31:0] ca0_nxt, sa0_nxt, ce0_nxt, se0_nxt;
  logic [52:0]        mce, mse, hsum, zsum;
  logic [31:0]        hmag;
  logic signed [31:0] h2_nxt;
  logic [63:0]        mpx, mpy, xsum, ysum;
  logic [55:0]        prx, pry, prz;
  res_t               res_nxt;

  // Valid bits along the pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LAT; k++) begin
        v_r[k] <= 1'b0;
      end
    end else if (en) begin
      v_r[0] <= ctl_i.valid;
      for (int k = 1; k < LAT; k++) begin
        v_r[k] <= v_r[k-1];
      end
    end
  end

  // Sideband follows its item.
  always_ff @(posedge clk) begin
    if (en) begin
      sd_r[0] <= side_i;
      for (int k = 1; k < LAT - 1; k++) begin
        sd_r[k] <= sd_r[k-1];
      end
    end
  end

  // Stage 0: undo the half-turn fold by negating sine and cosine.
  always_comb begin
    ca0_nxt = ctl_i.flip_az ? 32'(-ca_i) : 32'(ca_i);
    sa0_nxt = ctl_i.flip_az ? 32'(-sa_i) : 32'(sa_i);
    ce0_nxt = ctl_i.flip_el ? 32'(-ce_i) : 32'(ce_i);
    se0_nxt = ctl_i.flip_el ? 32'(-se_i) : 32'(se_i);
  end

  // Stage 2: round range*cos(el) to Q14 cm and range*sin(el) to the z quotient.
  always_comb begin
    mce    = pce1_r[52] ? 53'(-pce1_r) : 53'(pce1_r);
    mse    = pse1_r[52] ? 53'(-pse1_r) : 53'(pse1_r);
    hsum   = mce + H_BIAS;
    hmag   = hsum[51:20];
    h2_nxt = pce1_r[52] ? -$signed(hmag) : $signed(hmag);
    zsum   = mse + Z_BIAS;
  end

  // Stage 4: magnitude plus half divisor, then drop the power-of-two part.
  always_comb begin
    mpx  = px3_r[63] ? 64'(-px3_r) : 64'(px3_r);
    mpy  = py3_r[63] ? 64'(-py3_r) : 64'(py3_r);
    xsum = mpx + XY_BIAS;
    ysum = mpy + XY_BIAS;
  end

  // Stage 5: divide by 25 through the reciprocal.
  always_comb begin
    prx = {28'd0, nx4_r} * RECIP_25;
    pry = {28'd0, ny4_r} * RECIP_25;
    prz = {28'd0, nz4_r} * RECIP_25;
  end

  // Stage 6: sign, saturation and the all-zero record for a miss.
  always_comb begin
    res_nxt = '0;
    if (sd_r[5].valid_req) begin
      res_nxt.x_m           = sat23(qx5_r, xn5_r);
      res_nxt.y_m           = sat23(qy5_r, yn5_r);
      res_nxt.z_m           = sat23(qz5_r, zn5_r);
      res_nxt.intensity_out = sd_r[5].intensity;
      res_nxt.ring          = sd_r[5].channel;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (en) begin
      ca0_r  <= ca0_nxt;
      sa0_r  <= sa0_nxt;
      ce0_r  <= ce0_nxt;
      se0_r  <= se0_nxt;

      pce1_r <= $signed({1'b0, sd_r[0].range_cm}) * ce0_r;
      pse1_r <= $signed({1'b0, sd_r[0].range_cm}) * se0_r;
      ca1_r  <= ca0_r;
      sa1_r  <= sa0_r;

      h2_r   <= h2_nxt;
      nz2_r  <= zsum[51:24];
      zn2_r  <= pse1_r[52];
      ca2_r  <= ca1_r;
      sa2_r  <= sa1_r;

      px3_r  <= h2_r * ca2_r;
      py3_r  <= h2_r * sa2_r;
      nz3_r  <= nz2_r;
      zn3_r  <= zn2_r;

      nx4_r  <= xsum[61:34];
      ny4_r  <= ysum[61:34];
      xn4_r  <= px3_r[63];
      yn4_r  <= py3_r[63];
      nz4_r  <= nz3_r;
      zn4_r  <= zn3_r;

      qx5_r  <= prx[55:32];
      qy5_r  <= pry[55:32];
      qz5_r  <= prz[55:32];
      xn5_r  <= xn4_r;
      yn5_r  <= yn4_r;
      zn5_r  <= zn4_r;

      res_r  <= res_nxt;
    end
  end

  assign valid_o = v_r[LAT-1];
  assign res_o   = res_r;

endmodule

// File: design/lidar_spherical_to_cartesian_top.sv
// Lidar return to Cartesian point converter. Each request on the input stream
// (range in Q16.4 cm, azimuth and elevation as binary angles, intensity and
// laser channel) produces one point record with x, y and z in signed Q.12
// metres, saturated to 23 bits, plus the intensity and the ring number; a
// request whose tuser flag is low produces an all-zero record. The block takes
// one request per clock while in_tready is high: sine and cosine of both angles
// come from a chain of CORDIC_STAGES rotation cells that advance together,
// followed by a seven-stage scaling pipeline with one multiplier per product
// and stage. An output register with a one-entry skid buffer decouples the
// two sides; in_tready drops only when both hold a result that the consumer
// has not taken, and the whole pipeline then holds.
module lidar_spherical_to_cartesian_top #(
  parameter int CORDIC_STAGES = lsc_pkg::CORDIC_STAGES_DEF,
  parameter int ANGLE_BITS    = lsc_pkg::ANGLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // range_cm[19:0], azimuth[35:20], elevation[51:36], intensity[67:52],
  // channel[83:68], zero fill above
  input  logic [lsc_pkg::IN_TDATA_W-1:0]    in_tdata,
  // valid_req[0]
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // x_m[22:0], y_m[45:23], z_m[68:46], intensity_out[84:69], ring[100:85],
  // zero fill above
  output logic [lsc_pkg::OUT_TDATA_W-1:0]   out_tdata
);
  import lsc_pkg::*;

  localparam int ZW = ANGLE_BITS + 1;
  localparam logic signed [ZW-1:0] QUARTER = signed'(ZW'(1) << (ANGLE_BITS - 2));
  localparam logic signed [ZW-1:0] HALF    = signed'(ZW'(1) << (ANGLE_BITS - 1));

  // Angle to signed residual in [-quarter, quarter) plus a half-turn flag.
  function automatic logic [ZW:0] fold(input logic [15:0] a);
    logic [31:0]          turn;
    logic signed [ZW-1:0] z;
    logic                 flip;
    turn = {a, 16'h0000};
    z    = ZW'(signed'(turn[31 -: ANGLE_BITS]));
    flip = 1'b0;
    if (z >= QUARTER) begin
      z    = z - HALF;
      flip = 1'b1;
    end else if (z < -QUARTER) begin
      z    = z + HALF;
      flip = 1'b1;
    end
    return {flip, z};
  endfunction

  logic                 en;
  logic [ZW:0]          az_fold, el_fold;
  side_t                side_in;

  ctl_t                 ctl_s  [0:CORDIC_STAGES];
  side_t                side_s [0:CORDIC_STAGES];
  logic signed [XW-1:0] ax_s   [0:CORDIC_STAGES];
  logic signed [XW-1:0] ay_s   [0:CORDIC_STAGES];
  logic signed [ZW-1:0] az_s   [0:CORDIC_STAGES];
  logic signed [XW-1:0] ex_s   [0:CORDIC_STAGES];
  logic signed [XW-1:0] ey_s   [0:CORDIC_STAGES];
  logic signed [ZW-1:0] ez_s   [0:CORDIC_STAGES];

  logic                 sc_valid;
  res_t                 sc_res;

  logic                 out_valid_r, out_valid_nxt;
  res_t                 out_res_r, out_res_nxt;
  logic                 skid_valid_r, skid_valid_nxt;
  res_t                 skid_res_r, skid_res_nxt;
  logic                 sc_take, out_take;

  // The pipeline moves whenever the skid buffer is free.
  assign en        = !skid_valid_r;
  assign in_tready = en;

  // Unpack the request and fold both angles.
  always_comb begin
    side_in.valid_req = in_tuser;
    side_in.range_cm  = in_tdata[19:0];
    side_in.intensity = in_tdata[67:52];
    side_in.channel   = in_tdata[83:68];
    az_fold           = fold(in_tdata[35:20]);
    el_fold           = fold(in_tdata[51:36]);
  end

  // Entry stage of the cell chain.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_s[0].valid <= 1'b0;
    end else if (en) begin
      ctl_s[0].valid   <= in_tvalid;
      ctl_s[0].flip_az <= az_fold[ZW];
      ctl_s[0].flip_el <= el_fold[ZW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_s[0] <= side_in;
      ax_s[0]   <= GAIN_Q30;
      ay_s[0]   <= '0;
      az_s[0]   <= az_fold[ZW-1:0];
      ex_s[0]   <= GAIN_Q30;
      ey_s[0]   <= '0;
      ez_s[0]   <= el_fold[ZW-1:0];
    end
  end

  // Chain of rotation cells, one per micro-rotation.
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    lsc_cordic_cell #(
      .STAGE      (i),
      .ANGLE_BITS (ANGLE_BITS)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .ctl_i  (ctl_s[i]),
      .side_i (side_s[i]),
      .ax_i   (ax_s[i]),
      .ay_i   (ay_s[i]),
      .az_i   (az_s[i]),
      .ex_i   (ex_s[i]),
      .ey_i   (ey_s[i]),
      .ez_i   (ez_s[i]),
      .ctl_o  (ctl_s[i+1]),
      .side_o (side_s[i+1]),
      .ax_o   (ax_s[i+1]),
      .ay_o   (ay_s[i+1]),
      .az_o   (az_s[i+1]),
      .ex_o   (ex_s[i+1]),
      .ey_o   (ey_s[i+1]),
      .ez_o   (ez_s[i+1])
    );
  end

  // Scaling to metres and saturation.
  lsc_scale u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .ctl_i   (ctl_s[CORDIC_STAGES]),
    .side_i  (side_s[CORDIC_STAGES]),
    .ca_i    (ax_s[CORDIC_STAGES]),
    .sa_i    (ay_s[CORDIC_STAGES]),
    .ce_i    (ex_s[CORDIC_STAGES]),
    .se_i    (ey_s[CORDIC_STAGES]),
    .valid_o (sc_valid),
    .res_o   (sc_res)
  );

  // Output register with a one-entry skid buffer behind it.
  always_comb begin
    sc_take        = sc_valid && !skid_valid_r;
    out_take       = out_valid_r && out_tready;
    out_valid_nxt  = out_valid_r;
    out_res_nxt    = out_res_r;
    skid_valid_nxt = skid_valid_r;
    skid_res_nxt   = skid_res_r;
    if (sc_take) begin
      if (!out_valid_r || out_take) begin
        out_valid_nxt = 1'b1;
        out_res_nxt   = sc_res;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_res_nxt   = sc_res;
      end
    end else if (out_take) begin
      if (skid_valid_r) begin
        out_res_nxt    = skid_res_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_res_r};

endmodule

// File: design/lsc_checker.sv
`include "lidar_spherical_to_cartesian_top_defines.svh"

module lsc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [lsc_pkg::OUT_TDATA_W-1:0] out_tdata
);

  logic out_stall;

  // A result is offered but the consumer holds it off.
  assign out_stall = out_tvalid && !out_tready;

  // A stalled result stays offered and unchanged.
  `LSC_ASSERT_RUN(a_out_hold, out_stall |=> out_tvalid && $stable(out_tdata), "held result changed")

  // Reset empties the output register.
  `LSC_ASSERT_ALL(a_reset_empty, !rst_n |=> !out_tvalid, "result offered right after reset")

  // Requests are refused only after the consumer held off a waiting result.
  `LSC_ASSERT_RUN(a_ready_cause, !in_tready |-> $past(out_stall), "stall without backpressure")

endmodule

bind lidar_spherical_to_cartesian_top lsc_checker u_lsc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
